/* sv/absc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// absc_pkg: shared types and helpers for the address bar search classifier
// Item formats, classifier state, rule codes and ASCII class helpers.
// ----------------------------------------------------------------------------
package absc_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       has_char;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic       is_search;
      logic [3:0] rule_hit;
   } rsp_type;

   typedef struct packed {
      logic       seen_text;
      logic       first_is_query;
      logic [2:0] about_match;
      logic       space_pending;
      logic       inner_space;
      logic [1:0] scheme_match;
      logic       scheme_seen;
      logic       host_done;
      logic       colon_seen;
      logic       port_bad;
      logic [3:0] name_length;
      logic       localhost_ok;
      logic [2:0] ip_dots;
      logic [1:0] ip_digits;
      logic       ip_ok;
      logic       label_ok;
      logic       prev_dot;
      logic       any_dot;
      logic [1:0] tld_length;
      logic       tld_alpha;
   } state_type;

   localparam state_type STATE_RESET = '{
      seen_text:      1'b0,
      first_is_query: 1'b0,
      about_match:    3'd0,
      space_pending:  1'b0,
      inner_space:    1'b0,
      scheme_match:   2'd0,
      scheme_seen:    1'b0,
      host_done:      1'b0,
      colon_seen:     1'b0,
      port_bad:       1'b0,
      name_length:    4'd0,
      localhost_ok:   1'b1,
      ip_dots:        3'd0,
      ip_digits:      2'd0,
      ip_ok:          1'b1,
      label_ok:       1'b1,
      prev_dot:       1'b1,
      any_dot:        1'b0,
      tld_length:     2'd0,
      tld_alpha:      1'b1
   };

   // rule codes
   localparam logic [3:0] RULE_EMPTY     = 4'd0;
   localparam logic [3:0] RULE_QUERY     = 4'd1;
   localparam logic [3:0] RULE_ABOUT     = 4'd2;
   localparam logic [3:0] RULE_SPACE     = 4'd3;
   localparam logic [3:0] RULE_SCHEME    = 4'd4;
   localparam logic [3:0] RULE_BAD_PORT  = 4'd5;
   localparam logic [3:0] RULE_LOCALHOST = 4'd6;
   localparam logic [3:0] RULE_IPV4      = 4'd7;
   localparam logic [3:0] RULE_DOMAIN    = 4'd8;
   localparam logic [3:0] RULE_NO_DOMAIN = 4'd9;

   // about: progress codes
   localparam logic [2:0] ABOUT_MATCHED = 3'd6;
   localparam logic [2:0] ABOUT_FAILED  = 3'd7;

   // "://" progress codes
   localparam logic [1:0] SCH_IDLE  = 2'd0;
   localparam logic [1:0] SCH_COLON = 2'd1;
   localparam logic [1:0] SCH_SLASH = 2'd2;

   localparam logic [3:0] LOCAL_LEN   = 4'd9;
   localparam logic [3:0] NAME_SAT    = 4'd10;
   localparam logic [2:0] IP_DOTS_SAT = 3'd4;
   localparam logic [2:0] IP_DOTS_REQ = 3'd3;
   localparam logic [1:0] IP_DIG_MAX  = 2'd3;
   localparam logic [1:0] TLD_SAT     = 2'd2;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_DASH  = 8'h2D;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return is_upper(c) ? (c + 8'd32) : c;
   endfunction

   function automatic logic [7:0] about_char(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = 8'h61; // a
         3'd1:    r = 8'h62; // b
         3'd2:    r = 8'h6F; // o
         3'd3:    r = 8'h75; // u
         3'd4:    r = 8'h74; // t
         3'd5:    r = 8'h3A; // :
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] local_char(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd0:    r = 8'h6C; // l
         4'd1:    r = 8'h6F; // o
         4'd2:    r = 8'h63; // c
         4'd3:    r = 8'h61; // a
         4'd4:    r = 8'h6C; // l
         4'd5:    r = 8'h68; // h
         4'd6:    r = 8'h6F; // o
         4'd7:    r = 8'h73; // s
         4'd8:    r = 8'h74; // t
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/absc_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// absc_step: per-byte state update and verdict
// Applies one item to the classifier state and forms the verdict on the
// last item of a text. Pure combinational logic.
// ----------------------------------------------------------------------------
module absc_step (
   input  absc_pkg::state_type st_cur,
   input  absc_pkg::req_type   item,
   output absc_pkg::state_type st_next,
   output absc_pkg::rsp_type   verdict
);
   import absc_pkg::*;

   state_type  ns;
   logic [7:0] c;

   assign c = item.char_code;

   always_comb begin
      ns = st_cur;
      if (item.has_char) begin
         if (c == CH_SPACE) begin
            if (st_cur.seen_text) ns.space_pending = 1'b1;
         end else begin
            if (!st_cur.seen_text) begin
               ns.seen_text      = 1'b1;
               ns.first_is_query = (c == CH_QUERY);
            end else if (st_cur.space_pending) begin
               ns.inner_space   = 1'b1;
               ns.space_pending = 1'b0;
               if (ns.about_match < ABOUT_MATCHED) ns.about_match = ABOUT_FAILED;
            end

            if (ns.about_match < ABOUT_MATCHED) begin
               ns.about_match = (to_lower(c) == about_char(ns.about_match)) ?
                                (ns.about_match + 3'd1) : ABOUT_FAILED;
            end

            if (c == CH_COLON) begin
               ns.scheme_match = SCH_COLON;
            end else if (c == CH_SLASH && st_cur.scheme_match == SCH_COLON) begin
               ns.scheme_match = SCH_SLASH;
            end else if (c == CH_SLASH && st_cur.scheme_match == SCH_SLASH) begin
               ns.scheme_seen  = 1'b1;
               ns.scheme_match = SCH_IDLE;
            end else begin
               ns.scheme_match = SCH_IDLE;
            end

            if (!st_cur.host_done) begin
               if (c == CH_SLASH || c == CH_QUERY || c == CH_HASH) begin
                  ns.host_done = 1'b1;
               end else if (st_cur.colon_seen) begin
                  if (!is_digit(c)) ns.port_bad = 1'b1;
               end else if (c == CH_COLON) begin
                  ns.colon_seen = 1'b1;
               end else begin
                  // host name byte
                  if (st_cur.name_length < LOCAL_LEN) begin
                     if (to_lower(c) != local_char(st_cur.name_length))
                        ns.localhost_ok = 1'b0;
                  end else begin
                     ns.localhost_ok = 1'b0;
                  end
                  if (st_cur.name_length < NAME_SAT)
                     ns.name_length = st_cur.name_length + 4'd1;

                  if (c == CH_DOT) begin
                     if (st_cur.ip_digits == 2'd0) ns.ip_ok = 1'b0;
                     if (st_cur.ip_dots < IP_DOTS_SAT) ns.ip_dots = st_cur.ip_dots + 3'd1;
                     ns.ip_digits = 2'd0;
                  end else if (is_digit(c) && st_cur.ip_digits < IP_DIG_MAX) begin
                     ns.ip_digits = st_cur.ip_digits + 2'd1;
                  end else begin
                     ns.ip_ok = 1'b0;
                  end

                  if (c == CH_DOT) begin
                     if (st_cur.prev_dot) ns.label_ok = 1'b0;
                     ns.any_dot    = 1'b1;
                     ns.prev_dot   = 1'b1;
                     ns.tld_length = 2'd0;
                     ns.tld_alpha  = 1'b1;
                  end else begin
                     if (!is_alpha(c) && !is_digit(c) && c != CH_DASH) ns.label_ok = 1'b0;
                     ns.prev_dot = 1'b0;
                     if (st_cur.tld_length < TLD_SAT)
                        ns.tld_length = st_cur.tld_length + 2'd1;
                     if (!is_alpha(c)) ns.tld_alpha = 1'b0;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      if (!ns.seen_text) begin
         verdict = '{is_search: 1'b0, rule_hit: RULE_EMPTY};
      end else if (ns.first_is_query) begin
         verdict = '{is_search: 1'b1, rule_hit: RULE_QUERY};
      end else if (ns.about_match == ABOUT_MATCHED) begin
         verdict = '{is_search: 1'b0, rule_hit: RULE_ABOUT};
      end else if (ns.inner_space) begin
         verdict = '{is_search: 1'b1, rule_hit: RULE_SPACE};
      end else if (ns.scheme_seen) begin
         verdict = '{is_search: 1'b0, rule_hit: RULE_SCHEME};
      end else if (ns.port_bad) begin
         verdict = '{is_search: 1'b1, rule_hit: RULE_BAD_PORT};
      end else if (ns.name_length == LOCAL_LEN && ns.localhost_ok) begin
         verdict = '{is_search: 1'b0, rule_hit: RULE_LOCALHOST};
      end else if (ns.ip_ok && ns.ip_dots == IP_DOTS_REQ && ns.ip_digits != 2'd0) begin
         verdict = '{is_search: 1'b0, rule_hit: RULE_IPV4};
      end else if (ns.label_ok && ns.any_dot && ns.tld_length >= TLD_SAT && ns.tld_alpha) begin
         verdict = '{is_search: 1'b0, rule_hit: RULE_DOMAIN};
      end else begin
         verdict = '{is_search: 1'b1, rule_hit: RULE_NO_DOMAIN};
      end
   end

   // a verdict closes the text: start the next one from scratch
   assign st_next = item.last_char ? STATE_RESET : ns;

endmodule
`default_nettype wire

/* sv/address_bar_search_classifier.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// address_bar_search_classifier: location or search verdict for typed text
// Bytes go in one per item; the verdict comes out with the text's last item.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | char_code, has_char, last_char
//   rsp     | out       | rsp_valid/ready    | is_search, rule_hit
//
// One item per cycle sustained while no text's last item waits on the output. An item
// is held in the input register and applied to the state there; a text's verdict
// is then written to the output register, which drives rsp_valid.
// Reset clears the state to the start-of-text values and drops both valids.
// Only an item that ends a text waits on a full, stalled output register;
// other items keep flowing while a verdict waits to be taken.
// ----------------------------------------------------------------------------
module address_bar_search_classifier (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  absc_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output absc_pkg::rsp_type   rsp_data
);
   import absc_pkg::*;

   logic      in_valid_ff, in_valid_in;
   req_type   in_item_ff;
   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_data_ff;

   state_type st_next;
   rsp_type   verdict;
   logic      out_free, advance;

   absc_step u_step (
      .st_cur  (state_ff),
      .item    (in_item_ff),
      .st_next (st_next),
      .verdict (verdict)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_item_ff.last_char || out_free);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign state_in     = advance ? st_next : state_ff;
   assign out_valid_in = (advance && in_item_ff.last_char) ? 1'b1 :
                         (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_item_ff <= req_data;
      if (advance && in_item_ff.last_char) out_data_ff <= verdict;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
`default_nettype wire

/* sv/absc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// absc_checker: port-level checks for the classifier
// Watches the top level's ports; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module absc_checker (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input absc_pkg::rsp_type rsp_data
);
   import absc_pkg::*;

   // a stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("verdict changed or dropped while stalled");

   a_rule_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.rule_hit <= RULE_NO_DOMAIN)
      else $error("rule code out of range");

   a_search_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.is_search == (rsp_data.rule_hit == RULE_QUERY ||
                                           rsp_data.rule_hit == RULE_SPACE ||
                                           rsp_data.rule_hit == RULE_BAD_PORT ||
                                           rsp_data.rule_hit == RULE_NO_DOMAIN))
      else $error("search flag disagrees with rule code");

   // a verdict needs at least one accepted item after reset
   a_no_early_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("verdict shown right after reset");

endmodule

bind address_bar_search_classifier absc_checker u_absc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

/* verif/absc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absc_scoreboard: verdict scoreboard for the address bar search classifier
// Watches both channels. It rescans every accepted byte with its own copy of
// the classifier state, queues the verdict of each finished text, and
// compares the block's verdicts with that queue in order.
// ----------------------------------------------------------------------------
module absc_scoreboard (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  absc_pkg::req_type  req_data,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  absc_pkg::rsp_type  rsp_data,
   output int                 fail_count,
   output int                 verdicts_due
);
   import absc_pkg::*;

   localparam logic [47:0] ABOUT_WORD = "about:";
   localparam logic [71:0] LOCAL_WORD = "localhost";

   typedef struct packed {
      logic       started;
      logic       lead_query;
      logic [2:0] about_pos;
      logic       held_space;
      logic       mid_space;
      logic [1:0] sep_pos;
      logic       sep_found;
      logic       host_end;
      logic       port_mark;
      logic       port_err;
      logic [3:0] host_len;
      logic       lh_match;
      logic [2:0] dot_cnt;
      logic [1:0] dig_cnt;
      logic       quad_ok;
      logic       labels_ok;
      logic       after_dot;
      logic       has_dot;
      logic [1:0] tld_len;
      logic       tld_letters;
   } scan_type;

   scan_type scan;
   rsp_type  verdict_q[$];
   int       fails = 0;

   function automatic logic ascii_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic ascii_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [7:0] lower_of(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic scan_type scan_clear();
      scan_type s;
      s = '0;
      s.lh_match    = 1'b1;
      s.quad_ok     = 1'b1;
      s.labels_ok   = 1'b1;
      s.after_dot   = 1'b1;   // start of the host acts like a dot
      s.tld_letters = 1'b1;
      return s;
   endfunction

   function automatic void scan_host_byte(input logic [7:0] c);
      int k;
      k = scan.host_len;
      if (scan.host_len < LOCAL_LEN) begin
         if (lower_of(c) != LOCAL_WORD[8*(8-k) +: 8]) scan.lh_match = 1'b0;
      end else begin
         scan.lh_match = 1'b0;
      end
      if (scan.host_len < NAME_SAT) scan.host_len = scan.host_len + 4'd1;

      if (c == CH_DOT) begin
         if (scan.dig_cnt == 2'd0) scan.quad_ok = 1'b0;
         if (scan.dot_cnt < IP_DOTS_SAT) scan.dot_cnt = scan.dot_cnt + 3'd1;
         scan.dig_cnt = 2'd0;
      end else if (ascii_digit(c) && scan.dig_cnt < IP_DIG_MAX) begin
         scan.dig_cnt = scan.dig_cnt + 2'd1;
      end else begin
         scan.quad_ok = 1'b0;
      end

      if (c == CH_DOT) begin
         if (scan.after_dot) scan.labels_ok = 1'b0;
         scan.has_dot     = 1'b1;
         scan.after_dot   = 1'b1;
         scan.tld_len     = 2'd0;
         scan.tld_letters = 1'b1;
      end else begin
         if (!ascii_letter(c) && !ascii_digit(c) && c != CH_DASH) scan.labels_ok = 1'b0;
         scan.after_dot = 1'b0;
         if (scan.tld_len < TLD_SAT) scan.tld_len = scan.tld_len + 2'd1;
         if (!ascii_letter(c)) scan.tld_letters = 1'b0;
      end
   endfunction

   function automatic void scan_byte(input logic [7:0] c);
      int k;
      if (c == CH_SPACE) begin
         // a space only matters once more text follows it
         if (scan.started) scan.held_space = 1'b1;
      end else begin
         if (!scan.started) begin
            scan.started    = 1'b1;
            scan.lead_query = (c == CH_QUERY);
         end else if (scan.held_space) begin
            scan.mid_space = 1'b1;
            if (scan.about_pos < ABOUT_MATCHED) scan.about_pos = ABOUT_FAILED;
            scan.held_space = 1'b0;
         end

         if (scan.about_pos < ABOUT_MATCHED) begin
            k = scan.about_pos;
            scan.about_pos = (lower_of(c) == ABOUT_WORD[8*(5-k) +: 8]) ?
                             scan.about_pos + 3'd1 : ABOUT_FAILED;
         end

         if (c == CH_COLON) begin
            scan.sep_pos = SCH_COLON;
         end else if (c == CH_SLASH && scan.sep_pos == SCH_COLON) begin
            scan.sep_pos = SCH_SLASH;
         end else if (c == CH_SLASH && scan.sep_pos == SCH_SLASH) begin
            scan.sep_found = 1'b1;
            scan.sep_pos   = SCH_IDLE;
         end else begin
            scan.sep_pos = SCH_IDLE;
         end

         if (!scan.host_end) begin
            if (c == CH_SLASH || c == CH_QUERY || c == CH_HASH) begin
               scan.host_end = 1'b1;
            end else if (scan.port_mark) begin
               if (!ascii_digit(c)) scan.port_err = 1'b1;
            end else if (c == CH_COLON) begin
               scan.port_mark = 1'b1;
            end else begin
               scan_host_byte(c);
            end
         end
      end
   endfunction

   function automatic rsp_type classify();
      rsp_type v;
      v.is_search = 1'b0;
      if (!scan.started) begin
         v.rule_hit = RULE_EMPTY;
      end else if (scan.lead_query) begin
         v.is_search = 1'b1;
         v.rule_hit  = RULE_QUERY;
      end else if (scan.about_pos == ABOUT_MATCHED) begin
         v.rule_hit = RULE_ABOUT;
      end else if (scan.mid_space) begin
         v.is_search = 1'b1;
         v.rule_hit  = RULE_SPACE;
      end else if (scan.sep_found) begin
         v.rule_hit = RULE_SCHEME;
      end else if (scan.port_err) begin
         v.is_search = 1'b1;
         v.rule_hit  = RULE_BAD_PORT;
      end else if (scan.host_len == LOCAL_LEN && scan.lh_match) begin
         v.rule_hit = RULE_LOCALHOST;
      end else if (scan.quad_ok && scan.dot_cnt == IP_DOTS_REQ && scan.dig_cnt != 2'd0) begin
         v.rule_hit = RULE_IPV4;
      end else if (scan.labels_ok && scan.has_dot && scan.tld_len >= TLD_SAT &&
                   scan.tld_letters) begin
         v.rule_hit = RULE_DOMAIN;
      end else begin
         v.is_search = 1'b1;
         v.rule_hit  = RULE_NO_DOMAIN;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         scan = scan_clear();
         verdict_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $error("verdict with no finished text: is_search %0d rule_hit %0d",
                      rsp_data.is_search, rsp_data.rule_hit);
               fails++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.is_search !== want.is_search) begin
                  $error("is_search: expected %0d, actual %0d",
                         want.is_search, rsp_data.is_search);
                  fails++;
               end
               if (rsp_data.rule_hit !== want.rule_hit) begin
                  $error("rule_hit: expected %0d, actual %0d",
                         want.rule_hit, rsp_data.rule_hit);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.has_char) scan_byte(req_data.char_code);
            if (req_data.last_char) begin
               verdict_q.push_back(classify());
               scan = scan_clear();
            end
         end
      end
      fail_count   <= fails;
      verdicts_due <= verdict_q.size();
   end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the address bar search classifier
// Feeds typed texts byte by byte: one fixed text for most rules, then
// random texts shaped like domains, IPv4 addresses, localhost, about: pages,
// scheme URLs, searches and raw noise. Both channels idle at random and the
// receiver holds off once for a long stretch. absc_scoreboard does the checking.
// ----------------------------------------------------------------------------
module testbench;
   import absc_pkg::*;

   localparam int TEXT_ITEMS = 2000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      verdicts_due;

   int         items_sent = 0;
   bit         burst = 1'b0;
   logic [7:0] text_buf[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   address_bar_search_classifier i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   absc_scoreboard i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .verdicts_due (verdicts_due)
   );

   // mostly no gap or a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [7:0] pick_letter();
      logic [7:0] c;
      c = 8'h61 + 8'($urandom_range(0, 25));
      return $urandom_range(0, 1) ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] pick_any();
      string hot;
      hot = " .:/?#-09azAZ@";
      if ($urandom_range(0, 1)) return hot[$urandom_range(0, hot.len() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void add_letters(input int n);
      repeat (n) text_buf.push_back(pick_letter());
   endfunction

   function automatic void add_digits(input int n);
      repeat (n) text_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void add_any(input int n);
      repeat (n) text_buf.push_back(pick_any());
   endfunction

   function automatic void add_name(input int n);
      int roll;
      repeat (n) begin
         roll = $urandom_range(0, 9);
         if (roll < 7) text_buf.push_back(pick_letter());
         else if (roll < 9) add_digits(1);
         else text_buf.push_back(CH_DASH);
      end
   endfunction

   function automatic void put_word(input string s, input bit mixed);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mixed && c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
         text_buf.push_back(c);
      end
   endfunction

   // optional port, then optional path, query or fragment
   function automatic void add_tail();
      if ($urandom_range(0, 3) == 0) begin
         text_buf.push_back(CH_COLON);
         if ($urandom_range(0, 3) == 0) add_any($urandom_range(1, 3));
         else add_digits($urandom_range(0, 5));
      end
      if ($urandom_range(0, 2) == 0) begin
         case ($urandom_range(0, 2))
            0:       text_buf.push_back(CH_SLASH);
            1:       text_buf.push_back(CH_QUERY);
            default: text_buf.push_back(CH_HASH);
         endcase
         add_any($urandom_range(0, 5));
      end
   endfunction

   task automatic send_item(input logic [7:0] c, input logic has, input logic last);
      int gap;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_code: c, has_char: has, last_char: last};
      do @(posedge clock); while (!req_ready);
      if (has || last) items_sent++;
   endtask

   // the text ends either on its last byte or on a separate byte-less item
   task automatic send_text();
      bit marker;
      marker = (text_buf.size() == 0) || ($urandom_range(0, 9) == 0);
      burst  = ($urandom_range(0, 3) == 0);
      foreach (text_buf[i]) begin
         if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(text_buf[i], 1'b1, !marker && i == text_buf.size() - 1);
      end
      if (marker) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic send_fixed(input string s);
      text_buf.delete();
      put_word(s, 1'b0);
      send_text();
   endtask

   task automatic build_text();
      int n;
      text_buf.delete();
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) text_buf.push_back(CH_SPACE);
      case ($urandom_range(0, 9))
         0, 1: begin
            n = $urandom_range(0, 3);
            repeat (n) begin
               add_name(($urandom_range(0, 7) == 0) ? $urandom_range(8, 14)
                                                    : $urandom_range(1, 6));
               text_buf.push_back(CH_DOT);
            end
            if ($urandom_range(0, 3) != 0) add_letters($urandom_range(1, 4));
            else add_name($urandom_range(1, 3));
            add_tail();
         end
         2: begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 4;
            for (int p = 0; p < n; p++) begin
               if (p > 0) text_buf.push_back(CH_DOT);
               add_digits(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4)
                                                      : $urandom_range(1, 3));
            end
            add_tail();
         end
         3: begin
            put_word("localhost", 1'b1);
            case ($urandom_range(0, 3))
               0:       void'(text_buf.pop_back());
               1:       add_name($urandom_range(1, 3));
               default: ;
            endcase
            add_tail();
         end
         4: begin
            put_word("about:", 1'b1);
            if ($urandom_range(0, 3) == 0) void'(text_buf.pop_back());
            add_any($urandom_range(0, 6));
         end
         5: begin
            add_letters($urandom_range(1, 5));
            if ($urandom_range(0, 3) != 0) put_word("://", 1'b0);
            else put_word(":/", 1'b0);
            add_name($urandom_range(0, 6));
            add_any($urandom_range(0, 4));
         end
         6: begin
            n = $urandom_range(2, 4);
            for (int w = 0; w < n; w++) begin
               if (w > 0) repeat ($urandom_range(1, 2)) text_buf.push_back(CH_SPACE);
               add_letters($urandom_range(1, 6));
            end
         end
         7: begin
            text_buf.push_back(CH_QUERY);
            add_any($urandom_range(0, 6));
         end
         default: add_any($urandom_range(0, 12));
      endcase
      // broken variant: one byte replaced at random
      if (text_buf.size() > 0 && $urandom_range(0, 7) == 0)
         text_buf[$urandom_range(0, text_buf.size() - 1)] = pick_any();
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) text_buf.push_back(CH_SPACE);
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty text behind a byte-less item, then one text per rule but localhost and IPv4
      burst = 1'b0;
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);
      send_fixed("?");
      send_fixed("a b");
      send_fixed("x://");
      send_fixed("q:x");
      send_fixed("about:");
      send_fixed("a.bc");
      // NUL, tab and a high byte are plain non-letters
      text_buf = '{8'h00, 8'h09, 8'hFF};
      send_text();

      while (items_sent < TEXT_ITEMS) begin
         build_text();
         send_text();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (verdicts_due != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // receiver: random ready stretches and lulls, one long hold to back up the input
   initial begin
      int rounds;
      int lull;
      rounds = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                             : $urandom_range(1, 8)) @(posedge clock);
         rounds++;
         lull = (rounds == 25) ? 400 : pick_gap();
         if (lull > 0) begin
            rsp_ready <= 1'b0;
            repeat (lull) @(posedge clock);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
